// ===== hw/rtl/qse_pkg.sv =====
// Shared constants, types and sequencer states of the quicksort engine.
package qse_pkg;

	localparam int CAPACITY = 16;
	localparam int DATA_W   = 16;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int PTR_W    = IDX_W + 2;

	typedef logic [IDX_W-1:0]         idx_t;
	typedef logic [CNT_W-1:0]         cnt_t;
	typedef logic signed [PTR_W-1:0]  ptr_t;
	typedef logic signed [DATA_W-1:0] data_t;

	// one pending index range on the range stack
	typedef struct packed {
		idx_t lo;
		idx_t hi;
	} range_t;

	localparam int RANGE_W = $bits(range_t);

	// element store access for one cycle
	typedef struct packed {
		logic  we;
		idx_t  waddr;
		data_t wdata;
		logic  re;
		idx_t  raddr;
	} store_req_t;

	// range stack access for one cycle
	typedef struct packed {
		logic   we;
		idx_t   waddr;
		range_t wdata;
		logic   re;
		idx_t   raddr;
	} stack_req_t;

	typedef enum logic [3:0] {
		QS_IDLE,
		QS_POP,
		QS_POPW,
		QS_PIV,
		QS_IRD,
		QS_ICMP,
		QS_JCMP,
		QS_SWJ,
		QS_FIN1,
		QS_FIN2,
		QS_PUSH2,
		QS_ORD,
		QS_OUT
	} state_t;

endpackage

// ===== hw/rtl/quicksort_engine.sv =====
// Quicksort engine top level: sequencer with element store and range stack RAMs.
// Values are loaded one per request while busy is low; beyond 16 held values a
// request's value is dropped. A request with final_item set starts the sort, and
// busy stays high until the last sorted value has gone out. Each partition is
// paced by the single read and single write port of the element store. The
// sorted values then leave one per cycle on result_strobe, ascending, with
// last_out on the final one. The receiver cannot stall the output: every
// strobed cycle carries a result that must be taken.
module quicksort_engine (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic signed [15:0]    value,
	input  logic                  final_item,
	output logic                  result_strobe,
	output logic signed [15:0]    sorted_value,
	output logic                  last_out
);
	import qse_pkg::*;

	store_req_t store_req;
	stack_req_t stack_req;
	data_t      store_rdata;
	range_t     stack_rdata;
	logic [DATA_W-1:0]  store_rdata_raw;
	logic [RANGE_W-1:0] stack_rdata_raw;

	// map raw RAM words to typed views
	always_comb begin
		store_rdata  = data_t'(store_rdata_raw);
		stack_rdata  = range_t'(stack_rdata_raw);
		sorted_value = store_rdata;
	end

	qse_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.value         (value),
		.final_item    (final_item),
		.store_rdata   (store_rdata),
		.stack_rdata   (stack_rdata),
		.store_req     (store_req),
		.stack_req     (stack_req),
		.busy          (busy),
		.result_strobe (result_strobe),
		.last_out      (last_out)
	);

	qse_ram #(
		.WIDTH (DATA_W),
		.DEPTH (CAPACITY)
	) u_store (
		.clk   (clk),
		.we    (store_req.we),
		.waddr (store_req.waddr),
		.wdata (store_req.wdata),
		.re    (store_req.re),
		.raddr (store_req.raddr),
		.rdata (store_rdata_raw)
	);

	qse_ram #(
		.WIDTH (RANGE_W),
		.DEPTH (CAPACITY)
	) u_stack (
		.clk   (clk),
		.we    (stack_req.we),
		.waddr (stack_req.waddr),
		.wdata (stack_req.wdata),
		.re    (stack_req.re),
		.raddr (stack_req.raddr),
		.rdata (stack_rdata_raw)
	);

endmodule

// ===== hw/rtl/qse_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
module qse_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// read port, registered
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== hw/rtl/qse_ctrl.sv =====
// Sequencer and scan datapath: load, partition with range stack, emit in order.
module qse_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  qse_pkg::data_t     value,
	input  logic               final_item,
	input  qse_pkg::data_t     store_rdata,
	input  qse_pkg::range_t    stack_rdata,
	output qse_pkg::store_req_t store_req,
	output qse_pkg::stack_req_t stack_req,
	output logic               busy,
	output logic               result_strobe,
	output logic               last_out
);
	import qse_pkg::*;

	state_t state_q, state_d;
	cnt_t   count_q;
	cnt_t   sp_q;
	ptr_t   lo_q, hi_q, i_q, j_q;
	data_t  pivot_q;
	data_t  ai_q;
	idx_t   k_q;

	logic   accept;
	logic   room;
	cnt_t   cnt_next;
	ptr_t   i_inc, j_dec;
	logic   i_cont, j_cont;
	logic   push1_ok, push2_ok;
	logic   last_k;
	cnt_t   sp_after2;

	// left neighbour of the pivot's final place
	function automatic ptr_t j_dec_pivot();
		j_dec_pivot = i_q - PTR_W'(1);
	endfunction

	// index just below the pivot's final place
	function automatic idx_t j_dec_pivot_idx();
		ptr_t tmp;
		tmp = i_q - PTR_W'(1);
		j_dec_pivot_idx = tmp[IDX_W-1:0];
	endfunction

	// request and scan conditions
	always_comb begin
		accept    = start && (state_q == QS_IDLE);
		room      = count_q < CNT_W'(CAPACITY);
		cnt_next  = room ? count_q + CNT_W'(1) : count_q;
		i_inc     = i_q + PTR_W'(1);
		j_dec     = j_q - PTR_W'(1);
		i_cont    = (i_q < hi_q) && (store_rdata < pivot_q);
		j_cont    = (j_q >= lo_q) && (store_rdata > pivot_q);
		push1_ok  = (i_inc < hi_q) && (sp_q < CNT_W'(CAPACITY));
		push2_ok  = (lo_q < j_dec_pivot()) && (sp_q < CNT_W'(CAPACITY));
		sp_after2 = push2_ok ? sp_q + CNT_W'(1) : sp_q;
		last_k    = CNT_W'(k_q) == (count_q - CNT_W'(1));
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			QS_IDLE: begin
				if (accept && final_item) begin
					state_d = (cnt_next > CNT_W'(1)) ? QS_POP : QS_ORD;
				end
			end
			QS_POP:  state_d = QS_POPW;
			QS_POPW: state_d = QS_PIV;
			QS_PIV:  state_d = QS_IRD;
			QS_IRD:  state_d = QS_ICMP;
			QS_ICMP: begin
				if (!i_cont) begin
					state_d = QS_JCMP;
				end
			end
			QS_JCMP: begin
				if (!j_cont) begin
					state_d = (i_q < j_q) ? QS_SWJ : QS_FIN1;
				end
			end
			QS_SWJ:   state_d = QS_IRD;
			QS_FIN1:  state_d = QS_FIN2;
			QS_FIN2:  state_d = QS_PUSH2;
			QS_PUSH2: state_d = (sp_after2 == '0) ? QS_ORD : QS_POP;
			QS_ORD:   state_d = QS_OUT;
			QS_OUT: begin
				if (last_k) begin
					state_d = QS_IDLE;
				end
			end
			default: state_d = QS_IDLE;
		endcase
	end

	// memory requests and handshake outputs
	always_comb begin
		store_req     = '0;
		stack_req     = '0;
		busy          = state_q != QS_IDLE;
		result_strobe = state_q == QS_OUT;
		last_out      = (state_q == QS_OUT) && last_k;
		case (state_q)
			QS_IDLE: begin
				store_req.we    = accept && room;
				store_req.waddr = count_q[IDX_W-1:0];
				store_req.wdata = value;
				stack_req.we    = accept && final_item && (cnt_next > CNT_W'(1));
				stack_req.waddr = '0;
				stack_req.wdata.lo = '0;
				stack_req.wdata.hi = IDX_W'(cnt_next - CNT_W'(1));
			end
			QS_POP: begin
				stack_req.re    = 1'b1;
				stack_req.raddr = IDX_W'(sp_q - CNT_W'(1));
			end
			QS_POPW: begin
				store_req.re    = 1'b1;
				store_req.raddr = stack_rdata.hi;
			end
			QS_IRD: begin
				store_req.re    = 1'b1;
				store_req.raddr = i_inc[IDX_W-1:0];
			end
			QS_ICMP: begin
				store_req.re    = 1'b1;
				store_req.raddr = i_cont ? i_inc[IDX_W-1:0] : j_dec[IDX_W-1:0];
			end
			QS_JCMP: begin
				if (j_cont) begin
					store_req.re    = 1'b1;
					store_req.raddr = j_dec[IDX_W-1:0];
				end else if (i_q < j_q) begin
					store_req.we    = 1'b1;
					store_req.waddr = i_q[IDX_W-1:0];
					store_req.wdata = store_rdata;
				end
			end
			QS_SWJ: begin
				store_req.we    = 1'b1;
				store_req.waddr = j_q[IDX_W-1:0];
				store_req.wdata = ai_q;
			end
			QS_FIN1: begin
				store_req.we    = 1'b1;
				store_req.waddr = i_q[IDX_W-1:0];
				store_req.wdata = pivot_q;
			end
			QS_FIN2: begin
				store_req.we       = 1'b1;
				store_req.waddr    = hi_q[IDX_W-1:0];
				store_req.wdata    = ai_q;
				stack_req.we       = push1_ok;
				stack_req.waddr    = sp_q[IDX_W-1:0];
				stack_req.wdata.lo = i_inc[IDX_W-1:0];
				stack_req.wdata.hi = hi_q[IDX_W-1:0];
			end
			QS_PUSH2: begin
				stack_req.we       = push2_ok;
				stack_req.waddr    = sp_q[IDX_W-1:0];
				stack_req.wdata.lo = lo_q[IDX_W-1:0];
				stack_req.wdata.hi = j_dec_pivot_idx();
			end
			QS_ORD: begin
				store_req.re    = 1'b1;
				store_req.raddr = '0;
			end
			QS_OUT: begin
				store_req.re    = !last_k;
				store_req.raddr = k_q + IDX_W'(1);
			end
			default: begin
				store_req = '0;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= QS_IDLE;
			count_q <= '0;
			sp_q    <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				QS_IDLE: begin
					if (accept) begin
						count_q <= cnt_next;
						if (final_item && (cnt_next > CNT_W'(1))) begin
							sp_q <= CNT_W'(1);
						end
					end
				end
				QS_POP: sp_q <= sp_q - CNT_W'(1);
				QS_FIN2: begin
					if (push1_ok) begin
						sp_q <= sp_q + CNT_W'(1);
					end
				end
				QS_PUSH2: sp_q <= sp_after2;
				QS_OUT: begin
					if (last_k) begin
						count_q <= '0;
						sp_q    <= '0;
					end
				end
				default: begin
					sp_q <= sp_q;
				end
			endcase
		end
	end

	// scan datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			QS_POPW: begin
				lo_q <= ptr_t'({{(PTR_W-IDX_W){1'b0}}, stack_rdata.lo});
				hi_q <= ptr_t'({{(PTR_W-IDX_W){1'b0}}, stack_rdata.hi});
				i_q  <= ptr_t'({{(PTR_W-IDX_W){1'b0}}, stack_rdata.lo}) - PTR_W'(1);
				j_q  <= ptr_t'({{(PTR_W-IDX_W){1'b0}}, stack_rdata.hi});
			end
			QS_PIV: pivot_q <= store_rdata;
			QS_IRD: i_q <= i_inc;
			QS_ICMP: begin
				if (i_cont) begin
					i_q <= i_inc;
				end else begin
					ai_q <= store_rdata;
					j_q  <= j_dec;
				end
			end
			QS_JCMP: begin
				if (j_cont) begin
					j_q <= j_dec;
				end
			end
			QS_ORD: k_q <= '0;
			QS_OUT: begin
				if (!last_k) begin
					k_q <= k_q + IDX_W'(1);
				end
			end
			default: begin
				k_q <= k_q;
			end
		endcase
	end

	// checks
	a_sp_bound: assert property (@(posedge clk) disable iff (!arst_n)
		sp_q <= CNT_W'(CAPACITY))
		else $error("range stack pointer beyond capacity");

	a_idle_stack_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == QS_IDLE) |-> (sp_q == '0))
		else $error("range stack not empty while idle");

	a_last_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		(result_strobe && last_out) |=> (!busy && count_q == '0))
		else $error("run did not end after last result");

	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		(store_req.we && store_req.re) |-> (store_req.waddr != store_req.raddr))
		else $error("element store read and write hit the same entry");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("element count beyond capacity");

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the quicksort engine: directed and random sets of requests.
module tb_top;
	import qse_pkg::*;

	localparam int RANDOM_ITEMS = 440;
	localparam int IDLE_LIMIT   = 4000;
	localparam int DRAIN_CYCLES = 40;
	localparam int MAX_GAP      = 18;
	localparam int DIRECTED_N   = 23;

	// one row of the directed table; pinned rows carry their sorted value typed in
	typedef struct {
		int    value;
		logic  final_item;
		logic  pinned;
		int    pinned_value;
	} stim_row_t;

	typedef struct {
		data_t value;
		logic  last;
	} sorted_t;

	logic  clk;
	logic  arst_n     = 1'b0;
	logic  start      = 1'b0;
	data_t value      = '0;
	logic  final_item = 1'b0;
	logic  busy;
	logic  result_strobe;
	data_t sorted_value;
	logic  last_out;

	// predictor state
	data_t     held_values [CAPACITY];
	int        held_count = 0;
	int        span_lo [CAPACITY];
	int        span_hi [CAPACITY];
	int        span_depth = 0;
	sorted_t   sorted_fifo [$];
	sorted_t   expected_head;
	int        fail_count = 0;
	int        idle_cycles = 0;
	stim_row_t directed_rows [DIRECTED_N];

	quicksort_engine dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.value         (value),
		.final_item    (final_item),
		.result_strobe (result_strobe),
		.sorted_value  (sorted_value),
		.last_out      (last_out)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// push a pending index range, dropping it when it holds under two entries or the stack is full
	function automatic void push_span(int lo, int hi);
		if (lo < hi && span_depth < CAPACITY) begin
			span_lo[span_depth] = lo;
			span_hi[span_depth] = hi;
			span_depth++;
		end
	endfunction

	// partition [lo, hi] around its last element; return the pivot's final index
	function automatic int split_span(int lo, int hi);
		data_t pivot;
		data_t tmp;
		int    i;
		int    j;
		pivot = held_values[hi];
		i = lo - 1;
		j = hi;
		do begin
			do begin
				i++;
			end while (i < hi && held_values[i] < pivot);
			do begin
				j--;
			end while (j >= lo && held_values[j] > pivot);
			if (i < j) begin
				tmp = held_values[i];
				held_values[i] = held_values[j];
				held_values[j] = tmp;
			end
		end while (j > i);
		tmp = held_values[i];
		held_values[i] = held_values[hi];
		held_values[hi] = tmp;
		return i;
	endfunction

	// hold the value of an accepted request; on final, sort and queue the results
	function automatic void predict_request(data_t v, logic fin, logic pinned, data_t pinned_v);
		int      lo;
		int      hi;
		int      p;
		sorted_t entry;
		if (held_count < CAPACITY) begin
			held_values[held_count] = v;
			held_count++;
		end
		if (!fin)
			return;
		if (pinned) begin
			entry.value = pinned_v;
			entry.last  = 1'b1;
			sorted_fifo.push_back(entry);
		end else begin
			span_depth = 0;
			push_span(0, held_count - 1);
			while (span_depth > 0) begin
				span_depth--;
				lo = span_lo[span_depth];
				hi = span_hi[span_depth];
				p = split_span(lo, hi);
				push_span(p + 1, hi);
				push_span(lo, p - 1);
			end
			for (int k = 0; k < held_count; k++) begin
				entry.value = held_values[k];
				entry.last  = (k == held_count - 1);
				sorted_fifo.push_back(entry);
			end
		end
		held_count = 0;
	endfunction

	// wait a random gap (none when calm), then present one request until the engine takes it
	task automatic send_request(data_t v, logic fin, logic calm, logic pinned, data_t pinned_v);
		int gap;
		gap = calm ? 0 : $urandom_range(0, MAX_GAP);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start      <= 1'b1;
		value      <= v;
		final_item <= fin;
		do @(posedge clk); while (busy !== 1'b0);
		predict_request(v, fin, pinned, pinned_v);
	endtask

	// compare each strobed result with the oldest expectation
	always @(posedge clk) begin
		if (result_strobe === 1'b1) begin
			if (sorted_fifo.size() == 0) begin
				$error("sorted_value: no result expected, got %0d", sorted_value);
				fail_count++;
			end else begin
				expected_head = sorted_fifo.pop_front();
				if (sorted_value !== expected_head.value) begin
					$error("sorted_value: expected %0d, got %0d",
						expected_head.value, sorted_value);
					fail_count++;
				end
				if (last_out !== expected_head.last) begin
					$error("last_out: expected %0b, got %0b", expected_head.last, last_out);
					fail_count++;
				end
			end
		end
	end

	// end the run when nothing moves for too long
	always @(posedge clk) begin
		if ((start === 1'b1 && busy === 1'b0) || result_strobe === 1'b1)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("tb_top NOT OK");
			$finish;
		end
	end

	initial begin
		int    sent;
		int    n;
		int    mode;
		logic  calm;
		data_t v;
		data_t base;

		// single values, a pair, a full store with duplicates and a dropped final
		directed_rows = '{
			'{-32768, 1'b1, 1'b1, -32768},
			'{ 32767, 1'b1, 1'b1,  32767},
			'{     0, 1'b1, 1'b1,      0},
			'{ 32767, 1'b0, 1'b0,      0},
			'{-32768, 1'b1, 1'b0,      0},
			'{     5, 1'b0, 1'b0,      0},
			'{-32768, 1'b0, 1'b0,      0},
			'{ 32767, 1'b0, 1'b0,      0},
			'{     5, 1'b0, 1'b0,      0},
			'{     0, 1'b0, 1'b0,      0},
			'{    -1, 1'b0, 1'b0,      0},
			'{     1, 1'b0, 1'b0,      0},
			'{     5, 1'b0, 1'b0,      0},
			'{ 32767, 1'b0, 1'b0,      0},
			'{-32768, 1'b0, 1'b0,      0},
			'{   100, 1'b0, 1'b0,      0},
			'{  -100, 1'b0, 1'b0,      0},
			'{     5, 1'b0, 1'b0,      0},
			'{ 16384, 1'b0, 1'b0,      0},
			'{-16384, 1'b0, 1'b0,      0},
			'{     0, 1'b0, 1'b0,      0},
			'{ 12345, 1'b1, 1'b0,      0},
			'{    -1, 1'b1, 1'b1,     -1}
		};

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// walk the directed table
		for (int row = 0; row < DIRECTED_N; row++) begin
			send_request(data_t'(directed_rows[row].value), directed_rows[row].final_item,
				$urandom_range(0, 3) == 0, directed_rows[row].pinned,
				data_t'(directed_rows[row].pinned_value));
		end

		// random sets: mostly within capacity, some overflowing, varied value patterns
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4, 5, 6: n = $urandom_range(1, CAPACITY);
				7:                   n = CAPACITY;
				8:                   n = $urandom_range(CAPACITY + 1, CAPACITY + 4);
				default:             n = $urandom_range(1, 3);
			endcase
			mode = $urandom_range(0, 5);
			calm = ($urandom_range(0, 3) == 0);
			base = data_t'($urandom);
			for (int k = 0; k < n; k++) begin
				case (mode)
					0: v = data_t'($urandom);
					1: v = data_t'($urandom_range(0, 8) - 4);
					2: v = data_t'(base + k * 37);
					3: v = data_t'(base - k * 37);
					4: v = base;
					default: begin
						case ($urandom_range(0, 3))
							0:       v = data_t'(-32768);
							1:       v = data_t'(32767);
							2:       v = '0;
							default: v = data_t'(-1);
						endcase
					end
				endcase
				send_request(v, k == n - 1, calm, 1'b0, '0);
				sent++;
			end
		end
		start <= 1'b0;

		// drain outstanding results, then let the bench idle before reporting
		while (sorted_fifo.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

endmodule

// ===== files.f =====
hw/rtl/qse_pkg.sv
hw/rtl/qse_ram.sv
hw/rtl/qse_ctrl.sv
hw/rtl/quicksort_engine.sv
dv/tb_top.sv
